[design/yolo_region_decode_top_defines.svh]
// Assertion helpers shared by the decode block.
`ifndef YOLO_REGION_DECODE_TOP_DEFINES_SVH
`define YOLO_REGION_DECODE_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define YRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("yrd check failed");

// Next-cycle implication, disabled in reset.
`define YRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("yrd check failed");

`endif

[design/yrd_pkg.sv]
package yrd_pkg;

    // Default sizing limits
    localparam int MAX_CLASSES_DEF = 16;
    localparam int MAX_GRID_DEF    = 128;
    localparam int MAX_ANCHORS_DEF = 4;

    // Record layout: four box terms, objectness, then class scores
    localparam int FIELD_OBJ  = 4;
    localparam int FIELD_CLS0 = 5;

    // Fixed-point constants
    localparam logic [17:0] LOG2E_Q16 = 18'd94548;
    localparam logic [19:0] SIZE_SAT  = 20'hFFFFF;

    // Register reset values
    localparam logic [7:0]  RST_GRID_W    = 8'd13;
    localparam logic [7:0]  RST_GRID_H    = 8'd13;
    localparam logic [2:0]  RST_ANCHORS   = 3'd3;
    localparam logic [4:0]  RST_CLASSES   = 5'd7;
    localparam logic [15:0] RST_THRESHOLD = 16'd3277;
    localparam logic [47:0] RST_ANCHOR_W  = 48'd12816264201120;
    localparam logic [47:0] RST_ANCHOR_H  = 48'd11201378517712;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_GRID_W    = 3'd0,
        CFG_GRID_H    = 3'd1,
        CFG_ANCHORS   = 3'd2,
        CFG_CLASSES   = 3'd3,
        CFG_THRESHOLD = 3'd4,
        CFG_ANCHOR_W  = 3'd5,
        CFG_ANCHOR_H  = 3'd6
    } cfg_idx_t;

    // Which value of the record is being worked on
    typedef enum logic [2:0] {
        PH_OBJ = 3'd0,
        PH_TX  = 3'd1,
        PH_TY  = 3'd2,
        PH_TW  = 3'd3,
        PH_TH  = 3'd4,
        PH_CLS = 3'd5
    } phase_t;

    // Datapath operation for the current cycle
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_CAPTURE = 4'd1,
        OP_EXP1    = 4'd2,
        OP_EXP2    = 4'd3,
        OP_SIGLOAD = 4'd4,
        OP_SIGSAVE = 4'd5,
        OP_THRESH  = 4'd6,
        OP_XYLOAD  = 4'd7,
        OP_BOXMUL  = 4'd8,
        OP_BOXLOAD = 4'd9,
        OP_DIVSTEP = 4'd10,
        OP_BOXSAVE = 4'd11,
        OP_PMUL    = 4'd12,
        OP_OUTLOAD = 4'd13
    } op_t;

    // Kind of the captured request
    typedef enum logic [1:0] {
        KIND_TERM = 2'd0,
        KIND_OBJ  = 2'd1,
        KIND_CLS  = 2'd2
    } kind_t;

    typedef struct packed {
        op_t    op;
        phase_t phase;
    } yrd_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  div_done;
        logic  obj_pass;
        logic  out_free;
    } yrd_status_t;

    // 2^(i/16) in Q16, seventeen entries
    function automatic logic [17:0] pow2_frac(input logic [4:0] idx);
        logic [17:0] v;
        case (idx)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88753;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

[design/yrd_ctrl.sv]
module yrd_ctrl
    import yrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_tvalid,
    output logic        in_tready,
    input  yrd_status_t status,
    output yrd_cmd_t    cmd
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DISPATCH = 15'b000000000000010,
        S_EXP1     = 15'b000000000000100,
        S_EXP2     = 15'b000000000001000,
        S_SIGLOAD  = 15'b000000000010000,
        S_SIGDIV   = 15'b000000000100000,
        S_SIGSAVE  = 15'b000000001000000,
        S_THRESH   = 15'b000000010000000,
        S_XYLOAD   = 15'b000000100000000,
        S_BOXMUL   = 15'b000001000000000,
        S_BOXLOAD  = 15'b000010000000000,
        S_BOXDIV   = 15'b000100000000000,
        S_BOXSAVE  = 15'b001000000000000,
        S_PMUL     = 15'b010000000000000,
        S_OUTW     = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    // Hold state and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_OBJ;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Sequence the record decode
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd.op     = OP_NONE;
        cmd.phase  = phase_reg;
        in_tready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.kind)
                    KIND_OBJ:
                    begin
                        phase_next = PH_OBJ;
                        state_next = S_EXP1;
                    end
                    KIND_CLS:
                    begin
                        phase_next = PH_CLS;
                        state_next = S_EXP1;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_EXP1:
            begin
                cmd.op     = OP_EXP1;
                state_next = S_EXP2;
            end
            S_EXP2:
            begin
                cmd.op     = OP_EXP2;
                state_next = (phase_reg == PH_TW || phase_reg == PH_TH) ? S_BOXMUL : S_SIGLOAD;
            end
            S_SIGLOAD:
            begin
                cmd.op     = OP_SIGLOAD;
                state_next = S_SIGDIV;
            end
            S_SIGDIV:
            begin
                cmd.op = OP_DIVSTEP;
                if (status.div_done)
                begin
                    state_next = S_SIGSAVE;
                end
            end
            S_SIGSAVE:
            begin
                cmd.op = OP_SIGSAVE;
                case (phase_reg)
                    PH_OBJ:  state_next = S_THRESH;
                    PH_CLS:  state_next = S_PMUL;
                    default: state_next = S_XYLOAD;
                endcase
            end
            S_THRESH:
            begin
                cmd.op = OP_THRESH;
                if (status.obj_pass)
                begin
                    phase_next = PH_TX;
                    state_next = S_EXP1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_XYLOAD:
            begin
                cmd.op     = OP_XYLOAD;
                state_next = S_BOXDIV;
            end
            S_BOXMUL:
            begin
                cmd.op     = OP_BOXMUL;
                state_next = S_BOXLOAD;
            end
            S_BOXLOAD:
            begin
                cmd.op     = OP_BOXLOAD;
                state_next = S_BOXDIV;
            end
            S_BOXDIV:
            begin
                cmd.op = OP_DIVSTEP;
                if (status.div_done)
                begin
                    state_next = S_BOXSAVE;
                end
            end
            S_BOXSAVE:
            begin
                cmd.op     = OP_BOXSAVE;
                state_next = S_EXP1;
                case (phase_reg)
                    PH_TX: phase_next = PH_TY;
                    PH_TY: phase_next = PH_TW;
                    PH_TW: phase_next = PH_TH;
                    default: state_next = S_IDLE;
                endcase
            end
            S_PMUL:
            begin
                cmd.op     = OP_PMUL;
                state_next = S_OUTW;
            end
            S_OUTW:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUTLOAD;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[design/yrd_datapath.sv]
`include "yolo_region_decode_top_defines.svh"

module yrd_datapath
    import yrd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int MAX_GRID    = MAX_GRID_DEF,
    parameter int MAX_ANCHORS = MAX_ANCHORS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [47:0]   cfg_data,
    input  logic [15:0]   in_raw_value,
    input  logic          in_start,
    input  yrd_cmd_t      cmd,
    output yrd_status_t   status,
    input  logic          out_tready,
    output logic          out_tvalid,
    output logic [111:0]  out_tdata,
    output logic          out_tlast
);

    localparam int FP_W   = $clog2(MAX_CLASSES + FIELD_CLS0);
    localparam int AN_W   = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
    localparam int COL_W  = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int CMP_W  = ((COL_W > 8) ? COL_W : 8) + 1;
    localparam int XY_QB  = COL_W + 17;
    localparam int QB     = (XY_QB > 20) ? XY_QB : 20;
    localparam int QCNT_W = $clog2(QB + 1);
    localparam int DIV_W  = (COL_W + 24 > 57) ? COL_W + 24 : 57;

    localparam logic [CMP_W-1:0] C_OBJ  = CMP_W'(FIELD_OBJ);
    localparam logic [CMP_W-1:0] C_CLS0 = CMP_W'(FIELD_CLS0);

    // Configuration registers
    logic [7:0]  gw_reg, gh_reg;
    logic [2:0]  na_reg;
    logic [4:0]  nc_reg;
    logic [15:0] thr_reg;
    logic [47:0] aw_reg, ah_reg;

    // Position counters and captured request
    logic [FP_W-1:0]  fp_reg, fp_next, fp0, cur_fp_reg;
    logic [AN_W-1:0]  an_reg, an_next, an0, cur_an_reg;
    logic [COL_W-1:0] col_reg, col_next, col0, cur_col_reg;
    logic [COL_W-1:0] row_reg, row_next, row0, cur_row_reg;
    logic [15:0]      raw_reg;
    kind_t            kind_reg, kind0;
    logic [15:0]      terms [4];

    // Arithmetic registers
    logic signed [33:0] u_reg;
    logic signed [9:0]  p_reg;
    logic [16:0]        mant_reg;
    logic [32:0]        prod_reg;
    logic [DIV_W-1:0]   rem_reg, d_reg;
    logic [QB-1:0]      q_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [15:0]        sig_reg, obj_reg, prob_reg;
    logic [19:0]        box0_reg, box1_reg, box2_reg, box3_reg;

    // Result register
    logic        out_valid_reg;
    logic [3:0]  o_ci_reg;
    logic [15:0] o_prob_reg, o_x_reg, o_y_reg, o_obj_reg;
    logic [19:0] o_w_reg, o_h_reg;
    logic        o_last_reg;

    // Clamp registers to their legal ranges
    logic [7:0] gw_eff, gh_eff;
    logic [2:0] na_eff;
    logic [4:0] nc_eff;
    assign gw_eff = (gw_reg == 8'd0) ? 8'd1 :
                    ((32'(gw_reg) > MAX_GRID) ? 8'(MAX_GRID) : gw_reg);
    assign gh_eff = (gh_reg == 8'd0) ? 8'd1 :
                    ((32'(gh_reg) > MAX_GRID) ? 8'(MAX_GRID) : gh_reg);
    assign na_eff = (na_reg == 3'd0) ? 3'd1 :
                    ((32'(na_reg) > MAX_ANCHORS) ? 3'(MAX_ANCHORS) : na_reg);
    assign nc_eff = (nc_reg == 5'd0) ? 5'd1 :
                    ((32'(nc_reg) > MAX_CLASSES) ? 5'(MAX_CLASSES) : nc_reg);

    // Position of the incoming request and counter advance
    logic [CMP_W-1:0] fp1, an1, col1, row1;
    logic             fp_wrap, an_wrap, col_wrap;
    always_comb
    begin
        fp0  = in_start ? '0 : fp_reg;
        an0  = in_start ? '0 : an_reg;
        col0 = in_start ? '0 : col_reg;
        row0 = in_start ? '0 : row_reg;
        if (CMP_W'(fp0) < C_OBJ)
            kind0 = KIND_TERM;
        else if (CMP_W'(fp0) == C_OBJ)
            kind0 = KIND_OBJ;
        else
            kind0 = KIND_CLS;
        fp1      = CMP_W'(fp0) + CMP_W'(1);
        an1      = CMP_W'(an0) + CMP_W'(1);
        col1     = CMP_W'(col0) + CMP_W'(1);
        row1     = CMP_W'(row0) + CMP_W'(1);
        fp_wrap  = fp1 >= (CMP_W'(nc_eff) + C_CLS0);
        an_wrap  = an1 >= CMP_W'(na_eff);
        col_wrap = col1 >= CMP_W'(gw_eff);
        fp_next  = fp_wrap ? '0 : fp1[FP_W-1:0];
        an_next  = an0;
        col_next = col0;
        row_next = row0;
        if (fp_wrap)
        begin
            an_next = an_wrap ? '0 : an1[AN_W-1:0];
            if (an_wrap)
            begin
                col_next = col_wrap ? '0 : col1[COL_W-1:0];
                if (col_wrap)
                begin
                    row_next = (row1 >= CMP_W'(gh_eff)) ? '0 : row1[COL_W-1:0];
                end
            end
        end
    end

    // Select the exponent operand for the current phase
    logic [15:0]        base;
    logic signed [16:0] base_ext, t_val;
    logic               neg_op;
    always_comb
    begin
        case (cmd.phase)
            PH_TX:   base = terms[0];
            PH_TY:   base = terms[1];
            PH_TW:   base = terms[2];
            PH_TH:   base = terms[3];
            default: base = raw_reg;
        endcase
        neg_op   = !(cmd.phase == PH_TW || cmd.phase == PH_TH);
        base_ext = $signed({base[15], base});
        t_val    = neg_op ? -base_ext : base_ext;
    end

    // Scale by log2(e)
    logic signed [35:0] u_full;
    assign u_full = t_val * $signed({1'b0, LOG2E_Q16});

    // Interpolate 2^fraction
    logic [3:0]  e_idx;
    logic [11:0] e_r;
    logic [17:0] tab_lo, tab_hi, tab_diff;
    logic [24:0] interp;
    logic [17:0] mant_full;
    always_comb
    begin
        e_idx     = u_reg[23:20];
        e_r       = u_reg[19:8];
        tab_lo    = pow2_frac({1'b0, e_idx});
        tab_hi    = pow2_frac({1'b0, e_idx} + 5'd1);
        tab_diff  = tab_hi - tab_lo;
        interp    = tab_diff[12:0] * e_r;
        mant_full = tab_lo + 18'(interp >> 12);
    end

    // Sigmoid denominator and numerator
    logic [9:0]  neg_p;
    logic [40:0] e_val, den, sig_num;
    always_comb
    begin
        neg_p = 10'(-p_reg);
        if (p_reg > 10'sd23)
            e_val = 41'h1 << 40;
        else if (p_reg >= 10'sd0)
            e_val = 41'(mant_reg) << p_reg[4:0];
        else if (p_reg > -10'sd32)
            e_val = 41'(mant_reg >> neg_p[4:0]);
        else
            e_val = '0;
        den     = 41'd65536 + e_val;
        sig_num = 41'h1_0000_0000 + (den >> 1);
    end

    // Grid and anchor selection
    logic [7:0]       gsel;
    logic [COL_W-1:0] csel;
    logic [47:0]      anchors;
    logic [15:0]      anchor;
    always_comb
    begin
        gsel    = (cmd.phase == PH_TX || cmd.phase == PH_TW) ? gw_eff : gh_eff;
        csel    = (cmd.phase == PH_TX) ? cur_col_reg : cur_row_reg;
        anchors = (cmd.phase == PH_TW) ? aw_reg : ah_reg;
        case (cur_an_reg)
            AN_W'(0): anchor = anchors[15:0];
            AN_W'(1): anchor = anchors[31:16];
            AN_W'(2): anchor = anchors[47:32];
            default:  anchor = 16'd0;
        endcase
    end

    // Box size scaling before the divide
    logic signed [10:0] s_val, ns_val;
    logic [52:0]        box_num, box_bound;
    always_comb
    begin
        s_val     = $signed({p_reg[9], p_reg}) - 11'sd8;
        ns_val    = -s_val;
        box_bound = 53'(gsel) << 20;
        if (s_val >= 11'sd0)
            box_num = 53'(prod_reg) << s_val[4:0];
        else if (ns_val >= 11'sd33)
            box_num = '0;
        else
            box_num = 53'(prod_reg) >> ns_val[5:0];
    end

    // Class probability product
    logic [31:0] pm;
    assign pm = obj_reg * sig_reg;

    // Configuration writes, counters and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg        <= RST_GRID_W;
            gh_reg        <= RST_GRID_H;
            na_reg        <= RST_ANCHORS;
            nc_reg        <= RST_CLASSES;
            thr_reg       <= RST_THRESHOLD;
            aw_reg        <= RST_ANCHOR_W;
            ah_reg        <= RST_ANCHOR_H;
            fp_reg        <= '0;
            an_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            obj_reg       <= '0;
            box0_reg      <= '0;
            box1_reg      <= '0;
            box2_reg      <= '0;
            box3_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_GRID_W:    gw_reg  <= cfg_data[7:0];
                    CFG_GRID_H:    gh_reg  <= cfg_data[7:0];
                    CFG_ANCHORS:   na_reg  <= cfg_data[2:0];
                    CFG_CLASSES:   nc_reg  <= cfg_data[4:0];
                    CFG_THRESHOLD: thr_reg <= cfg_data[15:0];
                    CFG_ANCHOR_W:  aw_reg  <= cfg_data;
                    CFG_ANCHOR_H:  ah_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_CAPTURE)
            begin
                fp_reg  <= fp_next;
                an_reg  <= an_next;
                col_reg <= col_next;
                row_reg <= row_next;
            end
            // Load or advance the shared divider count
            case (cmd.op)
                OP_SIGLOAD: cnt_reg <= QCNT_W'(17);
                OP_XYLOAD:  cnt_reg <= QCNT_W'(XY_QB);
                OP_BOXLOAD:
                begin
                    if (prod_reg == '0 || s_val > 11'sd20 || box_num >= box_bound)
                        cnt_reg <= '0;
                    else
                        cnt_reg <= QCNT_W'(20);
                end
                OP_DIVSTEP:
                begin
                    if (cnt_reg != '0)
                        cnt_reg <= cnt_reg - QCNT_W'(1);
                end
                default: ;
            endcase
            // Objectness gate keeps a passing score, else clears the record
            if (cmd.op == OP_THRESH)
            begin
                if (sig_reg > thr_reg)
                begin
                    obj_reg <= sig_reg;
                end
                else
                begin
                    obj_reg  <= '0;
                    box0_reg <= '0;
                    box1_reg <= '0;
                    box2_reg <= '0;
                    box3_reg <= '0;
                end
            end
            if (cmd.op == OP_BOXSAVE)
            begin
                case (cmd.phase)
                    PH_TX:   box0_reg <= q_reg[19:0];
                    PH_TY:   box1_reg <= q_reg[19:0];
                    PH_TW:   box2_reg <= q_reg[19:0];
                    default: box3_reg <= q_reg[19:0];
                endcase
            end
            // Hold the result until taken
            if (cmd.op == OP_OUTLOAD)
                out_valid_reg <= 1'b1;
            else if (out_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CAPTURE)
        begin
            cur_fp_reg  <= fp0;
            cur_an_reg  <= an0;
            cur_col_reg <= col0;
            cur_row_reg <= row0;
            raw_reg     <= in_raw_value;
            kind_reg    <= kind0;
            if (kind0 == KIND_TERM)
                terms[fp0[1:0]] <= in_raw_value;
        end
        case (cmd.op)
            OP_EXP1: u_reg <= u_full[33:0];
            OP_EXP2:
            begin
                p_reg    <= u_reg[33:24];
                mant_reg <= mant_full[16:0];
            end
            OP_SIGLOAD:
            begin
                rem_reg <= DIV_W'(sig_num);
                d_reg   <= DIV_W'(den) << 16;
                q_reg   <= '0;
            end
            OP_SIGSAVE: sig_reg <= (|q_reg[QB-1:16]) ? 16'hFFFF : q_reg[15:0];
            OP_XYLOAD:
            begin
                rem_reg <= DIV_W'({csel, 16'h0000}) + DIV_W'(sig_reg);
                d_reg   <= DIV_W'(gsel) << (XY_QB - 1);
                q_reg   <= '0;
            end
            OP_BOXMUL: prod_reg <= mant_reg * anchor;
            OP_BOXLOAD:
            begin
                rem_reg <= DIV_W'(box_num);
                d_reg   <= DIV_W'(gsel) << 19;
                if (prod_reg == '0)
                    q_reg <= '0;
                else if (s_val > 11'sd20 || box_num >= box_bound)
                    q_reg <= QB'(SIZE_SAT);
                else
                    q_reg <= '0;
            end
            OP_DIVSTEP:
            begin
                // One quotient bit per cycle
                if (cnt_reg != '0)
                begin
                    if (rem_reg >= d_reg)
                    begin
                        rem_reg <= rem_reg - d_reg;
                        q_reg   <= {q_reg[QB-2:0], 1'b1};
                    end
                    else
                    begin
                        q_reg <= {q_reg[QB-2:0], 1'b0};
                    end
                    d_reg <= d_reg >> 1;
                end
            end
            OP_PMUL:
            begin
                if (pm[31:16] <= thr_reg || obj_reg == 16'd0)
                    prob_reg <= '0;
                else
                    prob_reg <= pm[31:16];
            end
            OP_OUTLOAD:
            begin
                o_ci_reg   <= 4'(CMP_W'(cur_fp_reg) - C_CLS0);
                o_prob_reg <= prob_reg;
                o_x_reg    <= box0_reg[15:0];
                o_y_reg    <= box1_reg[15:0];
                o_w_reg    <= box2_reg;
                o_h_reg    <= box3_reg;
                o_obj_reg  <= obj_reg;
                o_last_reg <= CMP_W'(cur_fp_reg) >= (CMP_W'(nc_eff) + C_OBJ);
            end
            default: ;
        endcase
    end

    // Status toward the controller
    assign status.kind     = kind_reg;
    assign status.div_done = (cnt_reg == '0);
    assign status.obj_pass = (sig_reg > thr_reg);
    assign status.out_free = !out_valid_reg || out_tready;

    assign out_tvalid = out_valid_reg;
    assign out_tlast  = o_last_reg;
    assign out_tdata  = {4'b0000, o_obj_reg, o_h_reg, o_w_reg, o_y_reg, o_x_reg,
                         o_prob_reg, o_ci_reg};

    `YRD_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, (cmd.op == OP_OUTLOAD),
        (!out_valid_reg || out_tready))
    `YRD_ASSERT_NEXT(a_gate_clears, clk, rst_n,
        (cmd.op == OP_THRESH && !(sig_reg > thr_reg)), (obj_reg == 16'd0))
    `YRD_ASSERT_NEXT(a_div_count, clk, rst_n, (cmd.op == OP_DIVSTEP && cnt_reg != '0),
        (cnt_reg == $past(cnt_reg) - QCNT_W'(1)))

endmodule

[design/yolo_region_decode_top.sv]
// Channel   | Direction | Payload
// s_axis    | in        | tdata: raw_value[15:0]; tuser: start_of_map
// m_axis    | out       | tdata: class/box fields; tlast: last_of_anchor
// cfg       | in        | write enable, register index, 48-bit data
//
// A box term is only captured. A class score takes one sigmoid divide
// (17 steps) plus any wait for the output register. Objectness takes one
// sigmoid divide when gated off; when it passes, three sigmoid divides, two
// box-centre divides and two box-size divides run on the one shared radix-2
// divider (a saturating size skips its divide).
// Reset restores the register defaults and clears the counters, objectness,
// box values and output valid. A result held on m_axis does not block a new
// request; only the next result waits for the output register to empty.
module yolo_region_decode_top
    import yrd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int MAX_GRID    = MAX_GRID_DEF,
    parameter int MAX_ANCHORS = MAX_ANCHORS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // raw_value[15:0]
    input  logic         s_axis_tuser,   // start_of_map
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // class_num[3:0], class_prob[19:4], box_x[35:20], box_y[51:36],
    // box_w[71:52], box_h[91:72], objectness[107:92], zero pad[111:108]
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    yrd_cmd_t    cmd;
    yrd_status_t status;

    // Sequencer
    yrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Counters, arithmetic and result register
    yrd_datapath #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_GRID    (MAX_GRID),
        .MAX_ANCHORS (MAX_ANCHORS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_raw_value (s_axis_tdata),
        .in_start     (s_axis_tuser),
        .cmd          (cmd),
        .status       (status),
        .out_tready   (m_axis_tready),
        .out_tvalid   (m_axis_tvalid),
        .out_tdata    (m_axis_tdata),
        .out_tlast    (m_axis_tlast)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import yrd_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [47:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;   // raw_value[15:0]
    logic         s_axis_tuser;   // start_of_map
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // class_num, class_prob, box_x, box_y, box_w, box_h, objectness, pad
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;

    yolo_region_decode_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    typedef struct packed {
        logic [3:0]  cls;
        logic [15:0] prob;
        logic [15:0] bx;
        logic [15:0] by;
        logic [19:0] bw;
        logic [19:0] bh;
        logic [15:0] obj;
        logic        last;
    } detection_t;

    // Directed row: raw value, map start, optional typed-in class probability
    typedef struct {
        logic [15:0] raw;
        logic        som;
        logic        pin;
        logic [15:0] prob;
    } stim_row_t;

    // Shadow registers of the decoder
    logic [7:0]  grid_w_q, grid_h_q;
    logic [2:0]  anchors_q;
    logic [4:0]  classes_q;
    logic [15:0] thresh_q;
    logic [47:0] anc_w_q, anc_h_q;

    // Shadow position and record state
    int unsigned fpos, apos, col, row;
    logic [15:0] box_terms [4];
    logic [19:0] box_q [4];
    logic [15:0] obj_q;

    detection_t  pending_dets [$];
    logic        pin_prob [$];
    logic [15:0] pin_value [$];
    int          errors;
    bit          rx_hold;
    int          hold_len;

    localparam int LOG2E = 94548;
    int unsigned frac_tab [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990,
                                   88753, 92682, 96785, 101070, 105545, 110218,
                                   115098, 120194, 125515, 131072};

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned clampv(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Split exp(t) into a Q16 mantissa and a power of two
    function automatic void exp_parts(input longint t, output longint unsigned mant,
                                      output longint p);
        longint          u;
        longint unsigned uq, q, idx, r;
        u = t * LOG2E + (64'sd1 <<< 32);
        uq = longint'(u) >> 8;
        q = uq & 16'hFFFF;
        idx = q >> 12;
        r = q & 12'hFFF;
        p = longint'(uq >> 16) - 256;
        mant = frac_tab[idx] + (((frac_tab[idx+1] - frac_tab[idx]) * r) >> 12);
    endfunction

    function automatic logic [15:0] sigmoid16(logic signed [15:0] x);
        longint unsigned m, e, den, s;
        longint          p;
        exp_parts(-longint'(x), m, p);
        if (p > 23) e = 64'd1 << 40;
        else if (p >= 0) e = m << p;
        else if (p > -32) e = m >> (-p);
        else e = 0;
        den = 65536 + e;
        s = ((64'd1 << 32) + den / 2) / den;
        return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [19:0] box_extent(logic signed [15:0] t,
                                               longint unsigned anc, longint unsigned g);
        longint unsigned m, prod, v;
        longint          p, s;
        exp_parts(longint'(t), m, p);
        prod = m * anc;
        if (prod == 0) return '0;
        s = p - 8;
        if (s > 20) return 20'hFFFFF;
        if (s >= 0) v = (prod << s) / g;
        else if (-s >= 64) v = 0;
        else v = (prod >> (-s)) / g;
        return (v > 20'hFFFFF) ? 20'hFFFFF : v[19:0];
    endfunction

    function automatic longint unsigned anchor_of(logic [47:0] r, int unsigned a);
        if (a >= 3) return 0;
        return (r >> (16 * a)) & 16'hFFFF;
    endfunction

    // Advance the shadow decoder by one request; queue a detection on class values
    task automatic decode_value(logic [15:0] raw, logic som);
        int unsigned gw, gh, na, nc, c;
        logic [15:0] s, sx, sy;
        longint unsigned pr;
        detection_t  d;
        gw = clampv(grid_w_q, 128);
        gh = clampv(grid_h_q, 128);
        na = clampv(anchors_q, 4);
        nc = clampv(classes_q, 16);
        if (som)
        begin
            fpos = 0; apos = 0; col = 0; row = 0;
        end
        if (fpos < 4)
            box_terms[fpos] = raw;
        else if (fpos == 4)
        begin
            s = sigmoid16(raw);
            if (s > thresh_q)
            begin
                sx = sigmoid16(box_terms[0]);
                sy = sigmoid16(box_terms[1]);
                obj_q = s;
                box_q[0] = 20'((((longint'(col % gw)) << 16) + sx) / gw);
                box_q[1] = 20'((((longint'(row % gh)) << 16) + sy) / gh);
                box_q[2] = box_extent(box_terms[2], anchor_of(anc_w_q, apos), gw);
                box_q[3] = box_extent(box_terms[3], anchor_of(anc_h_q, apos), gh);
            end
            else
            begin
                obj_q = '0;
                foreach (box_q[i]) box_q[i] = '0;
            end
        end
        else
        begin
            c = fpos - 5;
            pr = (longint'(obj_q) * sigmoid16(raw)) >> 16;
            if (pr <= thresh_q || obj_q == 0) pr = 0;
            d.cls  = c[3:0];
            d.prob = pr[15:0];
            d.bx   = box_q[0][15:0];
            d.by   = box_q[1][15:0];
            d.bw   = box_q[2];
            d.bh   = box_q[3];
            d.obj  = obj_q;
            d.last = (c + 1 >= nc);
            pending_dets.insert(pending_dets.size(), d);
        end
        fpos++;
        if (fpos >= 5 + nc)
        begin
            fpos = 0;
            apos++;
            if (apos >= na)
            begin
                apos = 0;
                col++;
                if (col >= gw)
                begin
                    col = 0;
                    row++;
                    if (row >= gh) row = 0;
                end
            end
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [47:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_GRID_W:    grid_w_q  = val[7:0];
            CFG_GRID_H:    grid_h_q  = val[7:0];
            CFG_ANCHORS:   anchors_q = val[2:0];
            CFG_CLASSES:   classes_q = val[4:0];
            CFG_THRESHOLD: thresh_q  = val[15:0];
            CFG_ANCHOR_W:  anc_w_q   = val;
            CFG_ANCHOR_H:  anc_h_q   = val;
            default: ;
        endcase
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Offer one request at the falling edge and hold it until accepted
    task automatic send_value(logic [15:0] raw, logic som, bit gaps, logic pin,
                              logic [15:0] pv);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= som;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (!som && fpos >= 5)
        begin
            pin_prob.insert(pin_prob.size(), pin);
            pin_value.insert(pin_value.size(), pv);
        end
        decode_value(raw, som);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_dets.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    // Random content for one value: mostly moderate, sometimes extreme
    function automatic logic [15:0] rand_raw();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 65535));
            1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($signed($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    // Well-formed records from the start of a map, with a rare stray restart
    task automatic send_records(int n_values);
        for (int i = 0; i < n_values; i++)
        begin
            logic [15:0] v;
            v = rand_raw();
            // push objectness high most of the time so boxes get decoded
            if (fpos == 4 && $urandom_range(0, 3) != 0) v = 16'($urandom_range(256, 2048));
            send_value(v, (i == 0) || ($urandom_range(0, 99) == 0), 1'b1, 1'b0, '0);
        end
    endtask

    // Receiver: random stalls, one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_hold)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 19) == 0)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            m_axis_tready <= 1'($urandom_range(0, 1));
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        rx_hold = 1'b0;
        hold_len = 0;
    end

    // Compare each accepted detection with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_dets.size() == 0)
            begin
                $error("detection with none expected: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                detection_t d;
                logic       pn;
                logic [15:0] pv;
                d  = pending_dets.pop_front();
                pn = pin_prob.pop_front();
                pv = pin_value.pop_front();
                if (pn && m_axis_tdata[19:4] !== pv)
                begin
                    $error("class_prob: expected %0d actual %0d", pv, m_axis_tdata[19:4]);
                    errors++;
                end
                if (m_axis_tdata[3:0] !== d.cls)
                begin
                    $error("class_num: expected %0d actual %0d", d.cls, m_axis_tdata[3:0]);
                    errors++;
                end
                if (m_axis_tdata[19:4] !== d.prob)
                begin
                    $error("class_prob: expected %0d actual %0d", d.prob, m_axis_tdata[19:4]);
                    errors++;
                end
                if (m_axis_tdata[35:20] !== d.bx)
                begin
                    $error("box_x: expected %0d actual %0d", d.bx, m_axis_tdata[35:20]);
                    errors++;
                end
                if (m_axis_tdata[51:36] !== d.by)
                begin
                    $error("box_y: expected %0d actual %0d", d.by, m_axis_tdata[51:36]);
                    errors++;
                end
                if (m_axis_tdata[71:52] !== d.bw)
                begin
                    $error("box_w: expected %0d actual %0d", d.bw, m_axis_tdata[71:52]);
                    errors++;
                end
                if (m_axis_tdata[91:72] !== d.bh)
                begin
                    $error("box_h: expected %0d actual %0d", d.bh, m_axis_tdata[91:72]);
                    errors++;
                end
                if (m_axis_tdata[107:92] !== d.obj)
                begin
                    $error("objectness: expected %0d actual %0d", d.obj,
                           m_axis_tdata[107:92]);
                    errors++;
                end
                if (m_axis_tlast !== d.last)
                begin
                    $error("last_of_anchor: expected %0d actual %0d", d.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    stim_row_t dir_rows [$];

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_GRID_W;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        grid_w_q = RST_GRID_W; grid_h_q = RST_GRID_H; anchors_q = RST_ANCHORS;
        classes_q = RST_CLASSES; thresh_q = RST_THRESHOLD;
        anc_w_q = RST_ANCHOR_W; anc_h_q = RST_ANCHOR_H;
        fpos = 0; apos = 0; col = 0; row = 0;
        foreach (box_q[i]) box_q[i] = '0;
        foreach (box_terms[i]) box_terms[i] = '0;
        obj_q = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: gated record (objectness at min), then extremes, defaults
        // in force; class probabilities of a gated record read as zero
        dir_rows.insert(dir_rows.size(), '{16'h0000, 1'b1, 1'b0, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'h7FFF, 1'b0, 1'b0, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'h8000, 1'b0, 1'b0, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'h7FFF, 1'b0, 1'b0, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'h8000, 1'b0, 1'b0, 16'h0});
        for (int c = 0; c < 7; c++)
            dir_rows.insert(dir_rows.size(), '{16'h7FFF, 1'b0, 1'b1, 16'h0});
        // Passing record with saturating size and extreme class scores
        dir_rows.insert(dir_rows.size(), '{16'h8000, 1'b0, 1'b0, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'h7FFF, 1'b0, 1'b0, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'h7FFF, 1'b0, 1'b0, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'h8000, 1'b0, 1'b0, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'h7FFF, 1'b0, 1'b0, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'h8000, 1'b0, 1'b1, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'h7FFF, 1'b0, 1'b0, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'h0000, 1'b0, 1'b0, 16'h0});
        dir_rows.insert(dir_rows.size(), '{16'hFFFF, 1'b0, 1'b0, 16'h0});
        foreach (dir_rows[i])
            send_value(dir_rows[i].raw, dir_rows[i].som, 1'b0, dir_rows[i].pin,
                       dir_rows[i].prob);
        wait_idle();

        // Fourth anchor (zero size), extreme values in several registers
        write_reg(CFG_ANCHORS, 48'd4);
        write_reg(CFG_CLASSES, 48'd1);
        write_reg(CFG_GRID_W, 48'd1);
        write_reg(CFG_GRID_H, 48'd2);
        write_reg(CFG_THRESHOLD, 48'd0);
        write_reg(CFG_ANCHOR_W, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_ANCHOR_H, 48'h0001_0100_8000);
        send_records(80);
        wait_idle();

        // Clamped oversize and zero registers, top threshold
        write_reg(CFG_GRID_W, 48'd255);
        write_reg(CFG_GRID_H, 48'd0);
        write_reg(CFG_ANCHORS, 48'd0);
        write_reg(CFG_CLASSES, 48'd31);
        write_reg(CFG_THRESHOLD, 48'hFFFF);
        send_records(60);
        wait_idle();

        // Long receiver hold-off while requests keep coming
        write_reg(CFG_GRID_W, 48'd3);
        write_reg(CFG_GRID_H, 48'd128);
        write_reg(CFG_ANCHORS, 48'd2);
        write_reg(CFG_CLASSES, 48'd16);
        write_reg(CFG_THRESHOLD, 48'd1000);
        write_reg(CFG_ANCHOR_W, 48'h0300_0080_0000);
        write_reg(CFG_ANCHOR_H, 48'hFFFF_0000_0200);
        fork
            begin
                rx_hold = 1'b1;
                hold_len = 0;
                while (hold_len < 600)
                begin
                    @(negedge clk);
                    hold_len++;
                end
                rx_hold = 1'b0;
            end
            send_records(120);
        join
        wait_idle();

        // Random settings, random records
        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(CFG_GRID_W, 48'($urandom_range(1, 6)));
            write_reg(CFG_GRID_H, 48'($urandom_range(1, 6)));
            write_reg(CFG_ANCHORS, 48'($urandom_range(1, 4)));
            write_reg(CFG_CLASSES, 48'($urandom_range(1, 8)));
            write_reg(CFG_THRESHOLD, 48'($urandom_range(0, 20000)));
            write_reg(CFG_ANCHOR_W, 48'({$urandom(), $urandom()}));
            write_reg(CFG_ANCHOR_H, 48'({$urandom(), $urandom()}));
            send_records(50);
            wait_idle();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
